// File: rtl/core/ffea_pkg.sv
package ffea_pkg;

    localparam int unsigned DATA_W = 32;

    localparam int unsigned DEF_FREE_SLOTS    = 16;
    localparam int unsigned DEF_USED_SLOTS    = 16;
    localparam int unsigned DEF_HEADER_BYTES  = 8;
    localparam int unsigned DEF_CONTROL_BYTES = 8;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_INIT  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOFIT   = 3'd1;
    localparam logic [2:0] ST_BADADDR = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_SMALL   = 3'd4;

    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_BYTES = 1'b1;

    // datapath micro-operations issued by the controller
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_INIT,
        OP_IDX_INC,
        OP_U_INC,
        OP_SET_NOFIT,
        OP_SET_FULL,
        OP_SET_BAD,
        OP_HOLD_FREE,
        OP_ALLOC,
        OP_HOLD_USED,
        OP_PREV_STEP,
        OP_HOLD_NEXT,
        OP_MERGE,
        OP_SHIFT_DN,
        OP_SHIFT_UP,
        OP_INS_PUT,
        OP_CNT_DEC,
        OP_PUT
    } dp_op_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       ua_small;
        logic       at_end;
        logic       fit;
        logic       rem_small;
        logic       u_end;
        logic       u_free;
        logic       u_match;
        logic       bad_bnd;
        logic       stop;
        logic       mprev;
        logic       mnext;
        logic       rm_last;
        logic       at_ins;
        logic       cnt_full;
        logic       out_busy;
    } dp_stat_t;

endpackage

// File: rtl/core/ffea_if.sv
interface ffea_in_if import ffea_pkg::*;;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [DATA_W-1:0] req_size;
    logic [DATA_W-1:0] user_addr;

    modport source (output valid, cmd, req_size, user_addr, input ready);
    modport sink (input valid, cmd, req_size, user_addr, output ready);
endinterface

interface ffea_out_if import ffea_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result_addr;
    logic [2:0]        status;

    modport source (output valid, result_addr, status, input ready);
    modport sink (input valid, result_addr, status, output ready);
endinterface

// File: rtl/core/ffea_dp.sv
module ffea_dp import ffea_pkg::*; #(
    parameter int unsigned FREE_SLOTS    = DEF_FREE_SLOTS,
    parameter int unsigned USED_SLOTS    = DEF_USED_SLOTS,
    parameter int unsigned HEADER_BYTES  = DEF_HEADER_BYTES,
    parameter int unsigned CONTROL_BYTES = DEF_CONTROL_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dp_op_t            op,
    output dp_stat_t          stat,
    input  logic              cfg_we,
    input  logic              cfg_idx,
    input  logic [DATA_W-1:0] cfg_data,
    input  logic [1:0]        in_cmd,
    input  logic [DATA_W-1:0] in_req_size,
    input  logic [DATA_W-1:0] in_user_addr,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_result_addr,
    output logic [2:0]        out_status
);

    localparam int unsigned FA = $clog2(FREE_SLOTS);
    localparam int unsigned IW = $clog2(FREE_SLOTS + 1);
    localparam int unsigned UA = $clog2(USED_SLOTS);
    localparam int unsigned UW = $clog2(USED_SLOTS + 1);
    localparam logic [DATA_W:0] HDR_W    = (DATA_W + 1)'(HEADER_BYTES);
    localparam logic [DATA_W:0] CTRL_W   = (DATA_W + 1)'(CONTROL_BYTES);
    localparam logic [DATA_W:0] MIN_SPAN = (DATA_W + 1)'(CONTROL_BYTES + HEADER_BYTES);
    localparam logic [DATA_W:0] LIMIT    = {1'b1, {DATA_W{1'b0}}};
    localparam logic [DATA_W:0] ALIGN3   = (DATA_W + 1)'(3);
    localparam logic [IW-1:0]   FREE_N   = IW'(FREE_SLOTS);
    localparam logic [UW-1:0]   USED_N   = UW'(USED_SLOTS);

    logic [DATA_W-1:0] fs_mem [FREE_SLOTS];
    logic [DATA_W-1:0] fl_mem [FREE_SLOTS];
    logic [DATA_W-1:0] us_mem [USED_SLOTS];
    logic [DATA_W-1:0] ul_mem [USED_SLOTS];
    logic [DATA_W-1:0] fs_q, fl_q, us_q, ul_q;

    logic [DATA_W-1:0] base_reg, bytes_reg;
    logic [1:0]        cmd_reg, cmd_next;
    logic              ua_small_reg, ua_small_next;
    logic [DATA_W:0]   blk_reg, blk_next;
    logic [DATA_W-1:0] s_reg, s_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     cnt_reg, cnt_next;
    logic [IW-1:0]     ins_reg, ins_next;
    logic [UW-1:0]     u_reg, u_next;
    logic [UA-1:0]     hu_reg, hu_next;
    logic [USED_SLOTS-1:0] valid_reg, valid_next;
    logic [DATA_W-1:0] hs_reg, hs_next, hl_reg, hl_next;
    logic              small_reg, small_next;
    logic [DATA_W-1:0] ul_reg, ul_next;
    logic [DATA_W:0]   e_reg, e_next;
    logic [DATA_W-1:0] ps_reg, ps_next, pl_reg, pl_next, nl_reg, nl_next;
    logic [DATA_W:0]   pend_reg, pend_next;
    logic              mprev_reg, mprev_next, mnext_reg, mnext_next;
    logic [DATA_W-1:0] res_addr_reg, res_addr_next;
    logic [2:0]        res_st_reg, res_st_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_addr_reg, out_addr_next;
    logic [2:0]        out_st_reg, out_st_next;

    logic              fw_en, uw_en;
    logic [FA-1:0]     fw_addr;
    logic [UA-1:0]     uw_addr;
    logic [DATA_W-1:0] fw_start, fw_len, uw_start, uw_len;

    logic [DATA_W:0]   region_sum, region_end, span, blk_raw;
    logic [IW-1:0]     idx_m1, idx_p1, cnt_m1;
    logic [IW:0]       idx_p1_w;
    logic              at_end;

    assign region_sum = {1'b0, base_reg} + {1'b0, bytes_reg};
    assign region_end = (region_sum > LIMIT) ? LIMIT : region_sum;
    assign span       = region_end - {1'b0, base_reg};
    assign blk_raw    = {1'b0, in_req_size} + HDR_W + ALIGN3;
    assign idx_m1     = idx_reg - IW'(1);
    assign idx_p1     = idx_reg + IW'(1);
    assign idx_p1_w   = {1'b0, idx_reg} + (IW + 1)'(1);
    assign cnt_m1     = cnt_reg - IW'(1);
    assign at_end     = idx_reg == cnt_reg;

    always_comb
    begin
        stat           = '0;
        stat.cmd       = cmd_reg;
        stat.ua_small  = ua_small_reg;
        stat.at_end    = at_end;
        stat.fit       = {1'b0, fl_q} >= blk_reg;
        stat.rem_small = small_reg;
        stat.u_end     = u_reg == USED_N;
        stat.u_free    = (u_reg != USED_N) && !valid_reg[u_reg[UA-1:0]];
        stat.u_match   = (u_reg != USED_N) && valid_reg[u_reg[UA-1:0]] && (us_q == s_reg);
        stat.bad_bnd   = ({1'b0, s_reg} < {1'b0, base_reg} + CTRL_W) || (e_reg > region_end);
        stat.stop      = at_end || (fs_q > s_reg);
        stat.mprev     = mprev_reg;
        stat.mnext     = mnext_reg;
        stat.rm_last   = idx_p1_w >= {1'b0, cnt_reg};
        stat.at_ins    = idx_reg == ins_reg;
        stat.cnt_full  = cnt_reg == FREE_N;
        stat.out_busy  = out_valid_reg && !out_ready;
    end

    always_comb
    begin
        cmd_next      = cmd_reg;
        ua_small_next = ua_small_reg;
        blk_next      = blk_reg;
        s_next        = s_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        ins_next      = ins_reg;
        u_next        = u_reg;
        hu_next       = hu_reg;
        valid_next    = valid_reg;
        hs_next       = hs_reg;
        hl_next       = hl_reg;
        small_next    = small_reg;
        ul_next       = ul_reg;
        e_next        = e_reg;
        ps_next       = ps_reg;
        pl_next       = pl_reg;
        nl_next       = nl_reg;
        pend_next     = pend_reg;
        mprev_next    = mprev_reg;
        mnext_next    = mnext_reg;
        res_addr_next = res_addr_reg;
        res_st_next   = res_st_reg;
        out_addr_next = out_addr_reg;
        out_st_next   = out_st_reg;
        out_valid_next = out_valid_reg && !out_ready;
        fw_en    = 1'b0;
        fw_addr  = idx_reg[FA-1:0];
        fw_start = fs_q;
        fw_len   = fl_q;
        uw_en    = 1'b0;
        uw_addr  = u_reg[UA-1:0];
        uw_start = hs_reg;
        uw_len   = blk_reg[DATA_W-1:0];
        unique case (op)
            OP_IDLE:
            begin
            end
            OP_LOAD:
            begin
                cmd_next      = in_cmd;
                blk_next      = blk_raw & ~ALIGN3;
                ua_small_next = {1'b0, in_user_addr} < HDR_W;
                s_next        = in_user_addr - HDR_W[DATA_W-1:0];
                idx_next      = '0;
                u_next        = '0;
                res_addr_next = '0;
                res_st_next   = ST_OK;
            end
            OP_INIT:
            begin
                valid_next = '0;
                if (span < MIN_SPAN)
                begin
                    cnt_next    = '0;
                    res_st_next = ST_SMALL;
                end
                else
                begin
                    cnt_next = IW'(1);
                    fw_en    = 1'b1;
                    fw_addr  = '0;
                    fw_start = base_reg + CTRL_W[DATA_W-1:0];
                    fw_len   = span[DATA_W-1:0] - CTRL_W[DATA_W-1:0];
                end
            end
            OP_IDX_INC:
                idx_next = idx_p1;
            OP_U_INC:
                u_next = u_reg + UW'(1);
            OP_SET_NOFIT:
                res_st_next = ST_NOFIT;
            OP_SET_FULL:
                res_st_next = ST_FULL;
            OP_SET_BAD:
                res_st_next = ST_BADADDR;
            OP_HOLD_FREE:
            begin
                hs_next    = fs_q;
                hl_next    = fl_q;
                small_next = ({1'b0, fl_q} - blk_reg) < HDR_W;
            end
            OP_ALLOC:
            begin
                uw_en    = 1'b1;
                uw_start = hs_reg;
                uw_len   = small_reg ? hl_reg : blk_reg[DATA_W-1:0];
                valid_next[u_reg[UA-1:0]] = 1'b1;
                res_addr_next = hs_reg + HDR_W[DATA_W-1:0];
                if (!small_reg)
                begin
                    fw_en    = 1'b1;
                    fw_start = hs_reg + blk_reg[DATA_W-1:0];
                    fw_len   = hl_reg - blk_reg[DATA_W-1:0];
                end
            end
            OP_HOLD_USED:
            begin
                hu_next = u_reg[UA-1:0];
                ul_next = ul_q;
                e_next  = {1'b0, s_reg} + {1'b0, ul_q};
            end
            OP_PREV_STEP:
            begin
                ps_next   = fs_q;
                pl_next   = fl_q;
                pend_next = {1'b0, fs_q} + {1'b0, fl_q};
                idx_next  = idx_p1;
            end
            OP_HOLD_NEXT:
            begin
                nl_next    = fl_q;
                mprev_next = (idx_reg != '0) && (pend_reg == {1'b0, s_reg});
                mnext_next = !at_end && ({1'b0, fs_q} == e_reg);
            end
            OP_MERGE:
            begin
                valid_next[hu_reg] = 1'b0;
                if (mprev_reg)
                begin
                    fw_en    = 1'b1;
                    fw_addr  = idx_m1[FA-1:0];
                    fw_start = ps_reg;
                    fw_len   = mnext_reg ? pl_reg + ul_reg + nl_reg : pl_reg + ul_reg;
                end
                else if (mnext_reg)
                begin
                    fw_en    = 1'b1;
                    fw_start = s_reg;
                    fw_len   = nl_reg + ul_reg;
                end
                else
                begin
                    ins_next = idx_reg;
                    if (!at_end)
                        idx_next = cnt_m1;
                end
            end
            OP_SHIFT_DN:
            begin
                fw_en   = 1'b1;
                fw_addr = idx_m1[FA-1:0];
            end
            OP_SHIFT_UP:
            begin
                fw_en    = 1'b1;
                fw_addr  = idx_p1[FA-1:0];
                idx_next = idx_m1;
            end
            OP_INS_PUT:
            begin
                fw_en    = 1'b1;
                fw_addr  = ins_reg[FA-1:0];
                fw_start = s_reg;
                fw_len   = ul_reg;
                cnt_next = cnt_reg + IW'(1);
            end
            OP_CNT_DEC:
                cnt_next = cnt_m1;
            OP_PUT:
            begin
                out_valid_next = 1'b1;
                out_addr_next  = res_addr_reg;
                out_st_next    = res_st_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fw_en)
        begin
            fs_mem[fw_addr] <= fw_start;
            fl_mem[fw_addr] <= fw_len;
        end
        if (uw_en)
        begin
            us_mem[uw_addr] <= uw_start;
            ul_mem[uw_addr] <= uw_len;
        end
        fs_q <= fs_mem[idx_reg[FA-1:0]];
        fl_q <= fl_mem[idx_reg[FA-1:0]];
        us_q <= us_mem[u_reg[UA-1:0]];
        ul_q <= ul_mem[u_reg[UA-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            bytes_reg     <= '0;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_idx == REG_BASE)
                base_reg <= cfg_data;
            if (cfg_we && cfg_idx == REG_BYTES)
                bytes_reg <= cfg_data;
            cnt_reg       <= cnt_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        ua_small_reg <= ua_small_next;
        blk_reg      <= blk_next;
        s_reg        <= s_next;
        idx_reg      <= idx_next;
        ins_reg      <= ins_next;
        u_reg        <= u_next;
        hu_reg       <= hu_next;
        hs_reg       <= hs_next;
        hl_reg       <= hl_next;
        small_reg    <= small_next;
        ul_reg       <= ul_next;
        e_reg        <= e_next;
        ps_reg       <= ps_next;
        pl_reg       <= pl_next;
        nl_reg       <= nl_next;
        pend_reg     <= pend_next;
        mprev_reg    <= mprev_next;
        mnext_reg    <= mnext_next;
        res_addr_reg <= res_addr_next;
        res_st_reg   <= res_st_next;
        out_addr_reg <= out_addr_next;
        out_st_reg   <= out_st_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_result_addr = out_addr_reg;
    assign out_status      = out_st_reg;

endmodule

// File: rtl/core/ffea_ctrl.sv
module ffea_ctrl import ffea_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_op_t   op
);

    typedef enum logic [18:0] {
        S_IDLE     = 19'h00001,
        S_DISPATCH = 19'h00002,
        S_INIT     = 19'h00004,
        S_FA_RD    = 19'h00008,
        S_FA_EV    = 19'h00010,
        S_UA_SCAN  = 19'h00020,
        S_RM_CHK   = 19'h00040,
        S_RM_RD    = 19'h00080,
        S_RM_WR    = 19'h00100,
        S_UF_RD    = 19'h00200,
        S_UF_EV    = 19'h00400,
        S_UF_BND   = 19'h00800,
        S_FF_RD    = 19'h01000,
        S_FF_EV    = 19'h02000,
        S_FF_DEC   = 19'h04000,
        S_INS_RD   = 19'h08000,
        S_INS_WR   = 19'h10000,
        S_INS_PUT  = 19'h20000,
        S_PUT      = 19'h40000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        op         = OP_IDLE;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            S_DISPATCH:
                case (stat.cmd)
                    CMD_ALLOC:
                        state_next = S_FA_RD;
                    CMD_FREE:
                        if (stat.ua_small)
                        begin
                            op         = OP_SET_BAD;
                            state_next = S_PUT;
                        end
                        else
                            state_next = S_UF_RD;
                    CMD_INIT:
                        state_next = S_INIT;
                    default:
                        state_next = S_PUT;
                endcase
            S_INIT:
            begin
                op         = OP_INIT;
                state_next = S_PUT;
            end
            S_FA_RD:
                state_next = S_FA_EV;
            S_FA_EV:
                if (stat.at_end)
                begin
                    op         = OP_SET_NOFIT;
                    state_next = S_PUT;
                end
                else if (stat.fit)
                begin
                    op         = OP_HOLD_FREE;
                    state_next = S_UA_SCAN;
                end
                else
                begin
                    op         = OP_IDX_INC;
                    state_next = S_FA_RD;
                end
            S_UA_SCAN:
                if (stat.u_end)
                begin
                    op         = OP_SET_FULL;
                    state_next = S_PUT;
                end
                else if (stat.u_free)
                begin
                    op         = OP_ALLOC;
                    state_next = stat.rem_small ? S_RM_CHK : S_PUT;
                end
                else
                    op = OP_U_INC;
            // close the gap left by a removed entry, one move per pass
            S_RM_CHK:
                if (stat.rm_last)
                begin
                    op         = OP_CNT_DEC;
                    state_next = S_PUT;
                end
                else
                begin
                    op         = OP_IDX_INC;
                    state_next = S_RM_RD;
                end
            S_RM_RD:
                state_next = S_RM_WR;
            S_RM_WR:
            begin
                op         = OP_SHIFT_DN;
                state_next = S_RM_CHK;
            end
            S_UF_RD:
                state_next = S_UF_EV;
            S_UF_EV:
                if (stat.u_end)
                begin
                    op         = OP_SET_BAD;
                    state_next = S_PUT;
                end
                else if (stat.u_match)
                begin
                    op         = OP_HOLD_USED;
                    state_next = S_UF_BND;
                end
                else
                begin
                    op         = OP_U_INC;
                    state_next = S_UF_RD;
                end
            S_UF_BND:
                if (stat.bad_bnd)
                begin
                    op         = OP_SET_BAD;
                    state_next = S_PUT;
                end
                else
                    state_next = S_FF_RD;
            S_FF_RD:
                state_next = S_FF_EV;
            S_FF_EV:
                if (stat.stop)
                begin
                    op         = OP_HOLD_NEXT;
                    state_next = S_FF_DEC;
                end
                else
                begin
                    op         = OP_PREV_STEP;
                    state_next = S_FF_RD;
                end
            S_FF_DEC:
                if (!stat.mprev && !stat.mnext && stat.cnt_full)
                begin
                    op         = OP_SET_FULL;
                    state_next = S_PUT;
                end
                else
                begin
                    op = OP_MERGE;
                    if (stat.mprev && stat.mnext)
                        state_next = S_RM_CHK;
                    else if (stat.mprev || stat.mnext)
                        state_next = S_PUT;
                    else if (stat.at_end)
                        state_next = S_INS_PUT;
                    else
                        state_next = S_INS_RD;
                end
            // open a slot by moving entries up from the tail
            S_INS_RD:
                state_next = S_INS_WR;
            S_INS_WR:
            begin
                op         = OP_SHIFT_UP;
                state_next = stat.at_ins ? S_INS_PUT : S_INS_RD;
            end
            S_INS_PUT:
            begin
                op         = OP_INS_PUT;
                state_next = S_PUT;
            end
            S_PUT:
                if (!stat.out_busy)
                begin
                    op         = OP_PUT;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/core/first_fit_extent_allocator.sv
// first-fit allocator over a byte region, with coalescing on free
// in_ch carries one item: cmd (allocate, free, init), req_size, user_addr.
// out_ch returns one item per input: result_addr and status.
// region_base (index 0) and region_bytes (index 1) are set through cfg_we,
// cfg_idx, cfg_data; the user is to set them only while no item is in progress,
// the block does not enforce this. items are handled one at a time; in_ch.ready
// is high only while idle. each table entry read is a registered memory read,
// then a compare. alloc scans the free table, then the used table, and moves
// entries down one at a time when an extent is used up; free scans the used
// table, checks the bounds, scans the free table, then merges, inserts with
// entries moved up one at a time, or moves entries down when both sides merge.
// the finished result sits in an output register; a stalled receiver only
// holds that register, the next item is still taken and waits at its end.
// reset clears the config registers, the free count, all used valid bits and
// the result valid; no table sweep is needed.
module first_fit_extent_allocator import ffea_pkg::*; #(
    parameter int unsigned FREE_SLOTS    = DEF_FREE_SLOTS,
    parameter int unsigned USED_SLOTS    = DEF_USED_SLOTS,
    parameter int unsigned HEADER_BYTES  = DEF_HEADER_BYTES,
    parameter int unsigned CONTROL_BYTES = DEF_CONTROL_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    ffea_in_if.sink           in_ch,
    ffea_out_if.source        out_ch,
    input  logic              cfg_we,
    input  logic              cfg_idx,
    input  logic [DATA_W-1:0] cfg_data
);

    dp_op_t   op;
    dp_stat_t stat;

    ffea_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .op       (op)
    );

    ffea_dp #(
        .FREE_SLOTS    (FREE_SLOTS),
        .USED_SLOTS    (USED_SLOTS),
        .HEADER_BYTES  (HEADER_BYTES),
        .CONTROL_BYTES (CONTROL_BYTES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .op              (op),
        .stat            (stat),
        .cfg_we          (cfg_we),
        .cfg_idx         (cfg_idx),
        .cfg_data        (cfg_data),
        .in_cmd          (in_ch.cmd),
        .in_req_size     (in_ch.req_size),
        .in_user_addr    (in_ch.user_addr),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .out_result_addr (out_ch.result_addr),
        .out_status      (out_ch.status)
    );

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |-> (op == OP_LOAD))
        else $error("accepted item not latched");

    a_put_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_PUT) |-> !(out_ch.valid && !out_ch.ready))
        else $error("stalled result overwritten");

    a_alloc_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_ALLOC) |-> stat.u_free)
        else $error("allocation into an occupied used slot");

    a_put_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_PUT) |=> in_ch.ready)
        else $error("controller not idle after result");

endmodule
